/* hdl/golden_section_line_search_defines.svh */
// Assertion macros shared by the line search RTL.
// The clock is i_clk and the active-low reset is i_rst_n in every user.
`ifndef GOLDEN_SECTION_LINE_SEARCH_DEFINES_SVH
`define GOLDEN_SECTION_LINE_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define GSLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GSLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GSLS_ASSERT(lbl, prop, msg)
`define GSLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/gsls_pkg.sv */
package gsls_pkg;

    // Step format: signed Q16.16.
    localparam int STEP_W    = 32;
    localparam int FRAC_BITS = 16;
    // Objective values are only compared.
    localparam int VAL_W     = 64;
    // A difference of two steps, and the bracket interval, need one more bit.
    localparam int DIFF_W    = STEP_W + 1;
    // Room for base + d + K*d before saturation to the step range.
    localparam int SUM_W     = STEP_W + 4;
    // Golden ratio conjugate 0.618034 as unsigned Q0.30.
    localparam int K_W       = 30;
    localparam logic [K_W-1:0] K_Q30 = 30'd663608954;
    // Configuration registers.
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] CFG_RESET =
        CFG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STEP = 2'd0,
        CFG_TOLERANCE    = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_B      = 3'd1,
        PH_EXPAND = 3'd2,
        PH_HI     = 3'd3,
        PH_LO     = 3'd4
    } t_phase;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] initial_step;
        logic [CFG_W-1:0] tolerance;
    } t_cfg;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              done;
        logic              ovf;
    } t_result;

    typedef struct packed {
        logic [STEP_W-1:0] pos;
        logic              ovf;
    } t_clamp;

    // Saturate a wide signed sum to the signed step range.
    function automatic t_clamp clamp_step(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        t_clamp                  r;
        hi = $signed({{(SUM_W-STEP_W+1){1'b0}}, {(STEP_W-1){1'b1}}});
        lo = ~hi;
        if (x > hi) begin
            r.pos = hi[STEP_W-1:0];
            r.ovf = 1'b1;
        end else if (x < lo) begin
            r.pos = lo[STEP_W-1:0];
            r.ovf = 1'b1;
        end else begin
            r.pos = x[STEP_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

/* hdl/gsls_mulk.sv */
// Multiplies a signed difference by 0.618034, truncating toward zero.
module gsls_mulk (
    input  logic [gsls_pkg::DIFF_W-1:0] i_d,
    output logic [gsls_pkg::DIFF_W-1:0] o_p
);

    logic                                     w_neg;
    logic [gsls_pkg::DIFF_W-1:0]              w_abs;
    logic [gsls_pkg::STEP_W-1:0]              w_mag;
    logic [gsls_pkg::STEP_W+gsls_pkg::K_W-1:0] w_prod;
    logic [gsls_pkg::STEP_W-1:0]              w_q;
    logic [gsls_pkg::DIFF_W-1:0]              w_q_ext;

    // The magnitude of a difference of two steps always fits in STEP_W bits.
    assign w_neg   = i_d[gsls_pkg::DIFF_W-1];
    assign w_abs   = w_neg ? (~i_d + 1'b1) : i_d;
    assign w_mag   = w_abs[gsls_pkg::STEP_W-1:0];

    // Exact product on the magnitude, then drop the Q0.30 fraction.
    assign w_prod  = {{gsls_pkg::K_W{1'b0}}, w_mag}
                   * {{gsls_pkg::STEP_W{1'b0}}, gsls_pkg::K_Q30};
    assign w_q     = w_prod[gsls_pkg::STEP_W+gsls_pkg::K_W-1:gsls_pkg::K_W];
    assign w_q_ext = {1'b0, w_q};

    // Restore the sign of the input.
    assign o_p     = w_neg ? (~w_q_ext + 1'b1) : w_q_ext;

endmodule

/* hdl/gsls_core.sv */
// Bracket and reduction state with its combinational update for one item.
module gsls_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  gsls_pkg::t_item    i_item,
    input  gsls_pkg::t_cfg     i_cfg,
    output logic               o_emit,
    output gsls_pkg::t_result  o_result
);

    gsls_pkg::t_phase r_phase, n_phase;

    logic signed [gsls_pkg::STEP_W-1:0] r_left_pos, n_left_pos;
    logic signed [gsls_pkg::STEP_W-1:0] r_mid_pos, n_mid_pos;
    logic signed [gsls_pkg::STEP_W-1:0] r_right_pos, n_right_pos;
    logic signed [gsls_pkg::STEP_W-1:0] r_inner_lo_pos, n_inner_lo_pos;
    logic signed [gsls_pkg::STEP_W-1:0] r_inner_hi_pos, n_inner_hi_pos;
    logic signed [gsls_pkg::VAL_W-1:0]  r_left_val, n_left_val;
    logic signed [gsls_pkg::VAL_W-1:0]  r_mid_val, n_mid_val;
    logic signed [gsls_pkg::VAL_W-1:0]  r_inner_lo_val, n_inner_lo_val;
    logic signed [gsls_pkg::VAL_W-1:0]  r_inner_hi_val, n_inner_hi_val;
    logic signed [gsls_pkg::DIFF_W-1:0] r_interval_len, n_interval_len;

    logic signed [gsls_pkg::VAL_W-1:0]  w_obj;
    logic signed [gsls_pkg::VAL_W-1:0]  w_lo_val;
    logic signed [gsls_pkg::VAL_W-1:0]  w_hi_val;
    logic                               w_swap;
    logic                               w_cont;
    logic                               w_go;
    logic                               w_keep_lo;
    logic [gsls_pkg::DIFF_W-1:0]        w_len_mag;
    logic signed [gsls_pkg::STEP_W-1:0] w_b_back;
    logic signed [gsls_pkg::STEP_W-1:0] w_b_from;
    logic signed [gsls_pkg::DIFF_W-1:0] w_d;
    logic signed [gsls_pkg::DIFF_W-1:0] w_p;
    logic signed [gsls_pkg::STEP_W-1:0] w_base;
    logic                               w_use_d;
    logic                               w_neg_p;
    logic signed [gsls_pkg::SUM_W-1:0]  w_sum;
    gsls_pkg::t_clamp                   w_clamp;
    gsls_pkg::t_clamp                   w_start;

    // Decisions taken on the incoming value.
    assign w_obj     = $signed(i_item.value);
    assign w_swap    = w_obj > r_left_val;
    assign w_cont    = r_mid_val > w_obj;
    assign w_lo_val  = (r_phase == gsls_pkg::PH_LO) ? w_obj : r_inner_lo_val;
    assign w_hi_val  = (r_phase == gsls_pkg::PH_HI) ? w_obj : r_inner_hi_val;
    assign w_keep_lo = w_lo_val >= w_hi_val;
    assign w_len_mag = r_interval_len[gsls_pkg::DIFF_W-1] ? (~r_interval_len + 1'b1)
                                                          : r_interval_len;
    assign w_go      = w_len_mag > gsls_pkg::DIFF_W'(i_cfg.tolerance);
    assign w_b_back  = w_swap ? r_mid_pos : r_left_pos;
    assign w_b_from  = w_swap ? r_left_pos : r_mid_pos;

    // Operands of the shared multiply and step adder.
    always_comb begin
        w_d     = r_interval_len;
        w_base  = '0;
        w_use_d = 1'b0;
        w_neg_p = 1'b0;
        unique case (r_phase)
            gsls_pkg::PH_B: begin
                w_d     = DIFF_W_SUB(w_b_from, w_b_back);
                w_base  = w_b_from;
                w_use_d = 1'b1;
            end
            gsls_pkg::PH_EXPAND: begin
                if (w_cont) begin
                    w_d     = DIFF_W_SUB(r_right_pos, r_mid_pos);
                    w_base  = r_right_pos;
                    w_use_d = 1'b1;
                end else begin
                    w_d     = DIFF_W_SUB(r_right_pos, r_left_pos);
                    w_base  = r_left_pos;
                end
            end
            gsls_pkg::PH_HI, gsls_pkg::PH_LO: begin
                w_d     = r_interval_len;
                w_base  = w_keep_lo ? r_inner_lo_pos : r_inner_hi_pos;
                w_neg_p = !w_keep_lo;
            end
            default: begin
                w_d = r_interval_len;
            end
        endcase
    end

    // Signed difference of two steps, one bit wider.
    function automatic logic signed [gsls_pkg::DIFF_W-1:0] DIFF_W_SUB(
        input logic signed [gsls_pkg::STEP_W-1:0] a,
        input logic signed [gsls_pkg::STEP_W-1:0] b
    );
        logic signed [gsls_pkg::DIFF_W-1:0] ea;
        logic signed [gsls_pkg::DIFF_W-1:0] eb;
        ea = gsls_pkg::DIFF_W'(a);
        eb = gsls_pkg::DIFF_W'(b);
        return ea - eb;
    endfunction

    gsls_mulk u_mulk (
        .i_d (w_d),
        .o_p (w_p)
    );

    // New step: base, plus d when expanding, plus or minus K*d; then saturate.
    assign w_sum   = gsls_pkg::SUM_W'(w_base)
                   + (w_use_d ? gsls_pkg::SUM_W'(w_d) : '0)
                   + (w_neg_p ? -gsls_pkg::SUM_W'(w_p) : gsls_pkg::SUM_W'(w_p));
    assign w_clamp = gsls_pkg::clamp_step(w_sum);
    assign w_start = gsls_pkg::clamp_step(
        $signed({{(gsls_pkg::SUM_W-gsls_pkg::CFG_W){1'b0}}, i_cfg.initial_step}));

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (!i_item.mode) begin
            n_phase = gsls_pkg::PH_B;
        end else begin
            unique case (r_phase)
                gsls_pkg::PH_B:      n_phase = gsls_pkg::PH_EXPAND;
                gsls_pkg::PH_EXPAND: n_phase = w_cont ? gsls_pkg::PH_EXPAND : gsls_pkg::PH_HI;
                gsls_pkg::PH_HI, gsls_pkg::PH_LO: begin
                    if (!w_go) begin
                        n_phase = gsls_pkg::PH_IDLE;
                    end else begin
                        n_phase = w_keep_lo ? gsls_pkg::PH_HI : gsls_pkg::PH_LO;
                    end
                end
                default:             n_phase = gsls_pkg::PH_IDLE;
            endcase
        end
    end

    // Bracket updates and the result of this item.
    always_comb begin
        n_left_pos     = r_left_pos;
        n_mid_pos      = r_mid_pos;
        n_right_pos    = r_right_pos;
        n_inner_lo_pos = r_inner_lo_pos;
        n_inner_hi_pos = r_inner_hi_pos;
        n_left_val     = r_left_val;
        n_mid_val      = r_mid_val;
        n_inner_lo_val = r_inner_lo_val;
        n_inner_hi_val = r_inner_hi_val;
        n_interval_len = r_interval_len;
        o_emit         = 1'b0;
        o_result       = '0;
        if (!i_item.mode) begin
            // A start item restarts the search from step zero.
            n_left_pos    = '0;
            n_left_val    = w_obj;
            n_mid_pos     = w_start.pos;
            o_emit        = 1'b1;
            o_result.step = w_start.pos;
            o_result.ovf  = w_start.ovf;
        end else begin
            unique case (r_phase)
                gsls_pkg::PH_B: begin
                    // Swap ends when the first trial step is uphill.
                    n_left_pos    = w_b_back;
                    n_left_val    = w_swap ? w_obj : r_left_val;
                    n_mid_pos     = w_b_from;
                    n_mid_val     = w_swap ? r_left_val : w_obj;
                    n_right_pos   = w_clamp.pos;
                    o_emit        = 1'b1;
                    o_result.step = w_clamp.pos;
                    o_result.ovf  = w_clamp.ovf;
                end
                gsls_pkg::PH_EXPAND: begin
                    o_emit        = 1'b1;
                    o_result.step = w_clamp.pos;
                    if (w_cont) begin
                        // Still falling: shift the bracket and expand again.
                        n_left_pos   = r_mid_pos;
                        n_left_val   = r_mid_val;
                        n_mid_pos    = r_right_pos;
                        n_mid_val    = w_obj;
                        n_right_pos  = w_clamp.pos;
                        o_result.ovf = w_clamp.ovf;
                    end else begin
                        // Bracket found: place the inner points.
                        n_interval_len = w_p;
                        n_inner_lo_pos = r_mid_pos;
                        n_inner_lo_val = r_mid_val;
                        n_inner_hi_pos = w_clamp.pos;
                    end
                end
                gsls_pkg::PH_HI, gsls_pkg::PH_LO: begin
                    n_inner_lo_val = w_lo_val;
                    n_inner_hi_val = w_hi_val;
                    o_emit         = 1'b1;
                    if (w_go) begin
                        n_interval_len = w_p;
                        o_result.step  = w_clamp.pos;
                        if (w_keep_lo) begin
                            n_left_pos     = r_inner_lo_pos;
                            n_left_val     = w_lo_val;
                            n_inner_lo_pos = r_inner_hi_pos;
                            n_inner_lo_val = w_hi_val;
                            n_inner_hi_pos = w_clamp.pos;
                        end else begin
                            n_right_pos    = r_inner_hi_pos;
                            n_inner_hi_pos = r_inner_lo_pos;
                            n_inner_hi_val = w_lo_val;
                            n_inner_lo_pos = w_clamp.pos;
                        end
                    end else begin
                        // Interval within tolerance: report the better inner point.
                        o_result.done = 1'b1;
                        o_result.step = (w_lo_val < w_hi_val) ? r_inner_lo_pos
                                                              : r_inner_hi_pos;
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gsls_pkg::PH_IDLE;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    // Bracket registers, written before they are ever read.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_left_pos     <= n_left_pos;
            r_mid_pos      <= n_mid_pos;
            r_right_pos    <= n_right_pos;
            r_inner_lo_pos <= n_inner_lo_pos;
            r_inner_hi_pos <= n_inner_hi_pos;
            r_left_val     <= n_left_val;
            r_mid_val      <= n_mid_val;
            r_inner_lo_val <= n_inner_lo_val;
            r_inner_hi_val <= n_inner_hi_val;
            r_interval_len <= n_interval_len;
        end
    end

endmodule

/* hdl/golden_section_line_search.sv */
// Golden-section line search sequencer. Send a start item (tuser = 0) with the
// objective value at step zero; the block answers with a step to evaluate, and
// every later item (tuser = 1) must carry the objective value at the step last
// returned. Each item yields one result: a Q16.16 step to query (done = 0) or
// the final minimizing step (done = 1); a value item sent while no search runs
// yields nothing, and a start item restarts the search at any time. Overflow
// marks a bracketing step that saturated the Q16.16 range. One item is taken
// every clock cycle while the result register is free or being drained; each
// item waits in the input register, then the bracket update (compare, 32x30
// golden-ratio multiply, saturating step adder) loads the result register. The
// configuration port always accepts writes; write it only while the block is idle.
`include "golden_section_line_search_defines.svh"
module golden_section_line_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gsls_pkg::VAL_W-1:0]        s_axis_tdata,  // [63:0] objective_value
    input  logic                              s_axis_tuser,  // [0] mode
    // Results.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gsls_pkg::STEP_W-1:0]       m_axis_tdata,  // [31:0] step_out
    output logic [1:0]                        m_axis_tuser,  // [0] done_res, [1] overflow
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gsls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gsls_pkg::CFG_W-1:0]        i_cfg_data
);

    logic              r_in_valid;
    gsls_pkg::t_item   r_item;
    logic              r_out_valid;
    gsls_pkg::t_result r_out;
    gsls_pkg::t_cfg    r_cfg;
    logic              w_advance;
    logic              w_emit;
    gsls_pkg::t_result w_result;

    // The held item moves on when the result register is free or being drained.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.mode  <= s_axis_tuser;
            r_item.value <= s_axis_tdata;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_step <= gsls_pkg::CFG_RESET;
            r_cfg.tolerance    <= gsls_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (gsls_pkg::t_cfg_index'(i_cfg_index))
                gsls_pkg::CFG_INITIAL_STEP: r_cfg.initial_step <= i_cfg_data;
                gsls_pkg::CFG_TOLERANCE:    r_cfg.tolerance    <= i_cfg_data;
                default:                    ;
            endcase
        end
    end

    gsls_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out.step;
    assign m_axis_tuser[0] = r_out.done;
    assign m_axis_tuser[1] = r_out.ovf;

    `GSLS_ASSERT(a_done_no_ovf, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1], "overflow flagged on a final step")
    `GSLS_ASSERT(a_in_hold, r_in_valid && !w_advance |=> r_in_valid && $stable(r_item), "held input item lost or changed")
    `GSLS_ASSERT(a_result_loaded, w_advance && w_emit |=> r_out_valid, "result of a transfer not presented")
    `GSLS_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !r_in_valid && !r_out_valid, "pipeline not empty after reset")

endmodule

/* verif/tb_golden_section_line_search.sv */
module tb_golden_section_line_search;
    timeunit 1ns;
    timeprecision 1ps;

    import gsls_pkg::*;

    localparam int GAP_MAX       = 19;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_SET = 200;
    localparam int NUM_SETS      = 8;
    localparam int MAX_REPORTS   = 10;

    localparam longint STEP_MAX = (longint'(1) <<< (STEP_W - 1)) - 1;
    localparam longint STEP_MIN = -STEP_MAX - 1;
    localparam longint VAL_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint VAL_MIN  = 64'sh8000_0000_0000_0000;
    localparam longint unsigned RATIO_Q30 = K_Q30;

    // Families of objective functions fed back to the search.
    typedef enum int {
        SHAPE_BOWL,
        SHAPE_SLOPE,
        SHAPE_FLAT,
        SHAPE_NOISE
    } t_shape;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [VAL_W-1:0]     s_axis_tdata  = '0;  // [63:0] objective_value
    logic                 s_axis_tuser  = 1'b0; // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [STEP_W-1:0]    m_axis_tdata;         // [31:0] step_out
    logic [1:0]           m_axis_tuser;         // [0] done_res, [1] overflow
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    golden_section_line_search DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting for their transfer and the step results they will cause.
    t_item   pending_items[$];
    t_result expected_steps[$];

    int          fail_count   = 0;
    int          results_made = 0;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    bit          send_burst   = 1'b0;
    bit          recv_burst   = 1'b0;
    bit          hold_go      = 1'b0;
    bit          rx_hold      = 1'b0;

    // Shadow copy of the search state and the configuration.
    longint unsigned cfg_step = CFG_RESET;
    longint unsigned cfg_tol  = CFG_RESET;
    longint a_pos  = 0, b_pos  = 0, c_pos  = 0;
    longint a_val  = 0, b_val  = 0, c_val  = 0;
    longint lo_pos = 0, hi_pos = 0, lo_val = 0, hi_val = 0;
    longint span   = 0;
    t_phase search_phase = PH_IDLE;
    // Step that the next value item has to be evaluated at.
    longint query_step = 0;

    function automatic int unsigned next_gap(inout bit burst);
        // Switch between random gaps and back-to-back stretches now and then.
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic longint unsigned abs64(input longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint fit64(input logic signed [64:0] s, inout bit ov);
        if (s[64] != s[63]) begin
            ov = 1'b1;
            return s[64] ? VAL_MIN : VAL_MAX;
        end
        return s[63:0];
    endfunction

    function automatic longint add_sat(input longint a, input longint b, inout bit ov);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        return fit64(s, ov);
    endfunction

    function automatic longint sub_sat(input longint a, input longint b, inout bit ov);
        logic signed [64:0] s;
        s = a;
        s = s - b;
        return fit64(s, ov);
    endfunction

    function automatic longint clamp32(input longint x, inout bit ov);
        if (x > STEP_MAX) begin
            ov = 1'b1;
            return STEP_MAX;
        end
        if (x < STEP_MIN) begin
            ov = 1'b1;
            return STEP_MIN;
        end
        return x;
    endfunction

    // 0.618034 * d on the magnitude, truncated toward zero, sign restored.
    function automatic longint scale_ratio(input longint d);
        longint unsigned m;
        longint unsigned p;
        m = abs64(d);
        p = (((m >> 32) * RATIO_Q30) << 2) + (((m & 64'hFFFF_FFFF) * RATIO_Q30) >> 30);
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Golden-ratio expansion: from + 1.618034 * (from - back), saturated.
    function automatic longint stretch(input longint back, input longint from, inout bit ov);
        longint d;
        longint t;
        longint s;
        d = sub_sat(from, back, ov);
        t = add_sat(d, scale_ratio(d), ov);
        s = add_sat(from, t, ov);
        return clamp32(s, ov);
    endfunction

    function automatic t_result pack_result(input longint step, input bit done, input bit ovf);
        t_result r;
        r.step = STEP_W'(step);
        r.done = done;
        r.ovf  = ovf;
        return r;
    endfunction

    // One golden-section reduction step, or the final choice once in tolerance.
    task automatic narrow_bracket(output t_result r);
        bit unused_ov;
        unused_ov = 1'b0;
        if (abs64(span) > cfg_tol) begin
            span = scale_ratio(span);
            if (lo_val >= hi_val) begin
                a_pos  = lo_pos;
                a_val  = lo_val;
                lo_pos = hi_pos;
                lo_val = hi_val;
                hi_pos = clamp32(add_sat(a_pos, span, unused_ov), unused_ov);
                r = pack_result(hi_pos, 1'b0, 1'b0);
                search_phase = PH_HI;
            end else begin
                c_pos  = hi_pos;
                c_val  = hi_val;
                hi_pos = lo_pos;
                hi_val = lo_val;
                lo_pos = clamp32(sub_sat(c_pos, span, unused_ov), unused_ov);
                r = pack_result(lo_pos, 1'b0, 1'b0);
                search_phase = PH_LO;
            end
        end else begin
            // The lower inner point wins only when strictly lower.
            r = pack_result((lo_val < hi_val) ? lo_pos : hi_pos, 1'b1, 1'b0);
            search_phase = PH_IDLE;
        end
    endtask

    // Advance the shadow search by one item and queue the step it answers with.
    task automatic predict_search_step(input t_item item);
        bit      ov;
        bit      unused_ov;
        bit      has_result;
        longint  v;
        longint  swap_pos;
        longint  swap_val;
        longint  next_pos;
        t_result r;
        ov         = 1'b0;
        unused_ov  = 1'b0;
        has_result = 1'b1;
        v          = item.value;
        if (!item.mode) begin
            // A start abandons whatever search runs.
            a_pos = 0;
            a_val = v;
            b_pos = clamp32(longint'(cfg_step), ov);
            r = pack_result(b_pos, 1'b0, ov);
            search_phase = PH_B;
        end else begin
            case (search_phase)
                PH_B: begin
                    b_val = v;
                    // Uphill first trial: search the other direction.
                    if (b_val > a_val) begin
                        swap_pos = a_pos;
                        swap_val = a_val;
                        a_pos    = b_pos;
                        a_val    = b_val;
                        b_pos    = swap_pos;
                        b_val    = swap_val;
                    end
                    c_pos = stretch(a_pos, b_pos, ov);
                    r = pack_result(c_pos, 1'b0, ov);
                    search_phase = PH_EXPAND;
                end
                PH_EXPAND: begin
                    c_val = v;
                    if (b_val > c_val) begin
                        next_pos = stretch(b_pos, c_pos, ov);
                        a_pos    = b_pos;
                        a_val    = b_val;
                        b_pos    = c_pos;
                        b_val    = c_val;
                        c_pos    = next_pos;
                        r = pack_result(c_pos, 1'b0, ov);
                    end else begin
                        span   = scale_ratio(sub_sat(c_pos, a_pos, unused_ov));
                        lo_pos = b_pos;
                        lo_val = b_val;
                        hi_pos = clamp32(add_sat(a_pos, span, unused_ov), unused_ov);
                        r = pack_result(hi_pos, 1'b0, 1'b0);
                        search_phase = PH_HI;
                    end
                end
                PH_HI: begin
                    hi_val = v;
                    narrow_bracket(r);
                end
                PH_LO: begin
                    lo_val = v;
                    narrow_bracket(r);
                end
                default: begin
                    // A value with no search running is dropped.
                    search_phase = PH_IDLE;
                    has_result   = 1'b0;
                end
            endcase
        end
        if (has_result) begin
            expected_steps.push_back(r);
            query_step = longint'($signed(r.step));
            results_made++;
        end
    endtask

    task automatic send_item(input logic mode, input logic [VAL_W-1:0] value);
        t_item item;
        item.mode  = mode;
        item.value = value;
        predict_search_step(item);
        pending_items.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_INITIAL_STEP) cfg_step = data;
        else cfg_tol = data;
    endtask

    // Objective value at step x, saturated to the 64-bit range.
    function automatic longint objective(input t_shape shape, input longint ctr,
                                         input longint gain, input longint ofs,
                                         input longint x);
        logic signed [127:0] d;
        logic signed [127:0] q;
        case (shape)
            SHAPE_BOWL: begin
                d = x;
                d = d - ctr;
                q = d * d;
                q = q * gain;
                q = q + ofs;
            end
            SHAPE_SLOPE: begin
                q = x;
                q = q * gain;
                q = q + ofs;
            end
            SHAPE_FLAT: q = ofs;
            default:    q = $signed({$urandom, $urandom});
        endcase
        if (q[127:63] != {65{q[127]}}) return q[127] ? VAL_MIN : VAL_MAX;
        return q[63:0];
    endfunction

    // One search on a random objective, answering every step the block asks for.
    task automatic run_search(input int pause_at);
        t_shape shape;
        longint ctr;
        longint gain;
        longint ofs;
        int     count;
        int     pick;
        pick  = $urandom_range(0, 99);
        shape = (pick < 60) ? SHAPE_BOWL :
                (pick < 75) ? SHAPE_SLOPE :
                (pick < 85) ? SHAPE_FLAT : SHAPE_NOISE;
        ctr   = longint'($signed($urandom)) >>> $urandom_range(0, 26);
        gain  = $urandom_range(1, 1 << $urandom_range(0, 16));
        if (shape == SHAPE_SLOPE && $urandom_range(0, 1) == 1) gain = -gain;
        ofs   = $signed({$urandom, $urandom}) >>> $urandom_range(1, 40);
        send_item(1'b0, objective(shape, ctr, gain, ofs, 0));
        count = 1;
        while (search_phase != PH_IDLE && count < 400) begin
            // Now and then the search is abandoned; the next start restarts it.
            if ($urandom_range(0, 59) == 0) break;
            // The sender pauses until every result has come back.
            if (count == pause_at || $urandom_range(0, 149) == 0) wait_drained();
            if ($urandom_range(0, 49) == 0) send_item(1'b1, {$urandom, $urandom});
            else send_item(1'b1, objective(shape, ctr, gain, ofs, query_step));
            count++;
        end
        // Stray values after the search; they draw no result once it has finished.
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            send_item(1'b1, {$urandom, $urandom});
    endtask

    // Input driver: presents the oldest pending item after its random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_wait      = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                void'(pending_items.pop_front());
                send_wait = next_gap(send_burst);
            end
            if (send_wait > 0) begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0].value;
                s_axis_tuser  <= pending_items[0].mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expected step.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait      = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_steps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: step %h done %b overflow %b",
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                end else begin
                    want = expected_steps.pop_front();
                    if (m_axis_tdata !== want.step || m_axis_tuser[0] !== want.done ||
                        m_axis_tuser[1] !== want.ovf) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result mismatch: expected step %h done %b overflow %b,",
                                      " got step %h done %b overflow %b"},
                                     want.step, want.done, want.ovf,
                                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
                recv_wait = next_gap(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !rx_hold;
            end
        end
    end

    // Long receiver hold-off so that the block backs up and stalls its input.
    initial begin
        while (!hold_go) @(posedge i_clk);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus: directed items, then random searches under several settings.
    initial begin
        logic [CFG_W-1:0] set_step;
        logic [CFG_W-1:0] set_tol;
        int               target;
        int               pause_at;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Values with no search running, then extreme values and restarts.
        send_item(1'b1, '0);
        send_item(1'b1, VAL_MIN);
        send_item(1'b0, VAL_MAX);
        send_item(1'b1, VAL_MIN);
        send_item(1'b1, VAL_MIN);
        send_item(1'b0, VAL_MIN);
        send_item(1'b1, VAL_MAX);
        send_item(1'b1, '0);
        send_item(1'b1, -1);
        send_item(1'b1, 64'h5555_5555_5555_5555);
        send_item(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        // A falling run that keeps the bracket expanding, then a rise.
        send_item(1'b0, '0);
        for (int k = 1; k <= 5; k++) send_item(1'b1, -k);
        send_item(1'b1, VAL_MAX);
        send_item(1'b1, 1);
        send_item(1'b1, VAL_MAX);
        send_item(1'b1, VAL_MIN);

        for (int cfg_round = 0; cfg_round < NUM_SETS; cfg_round++) begin
            if (cfg_round > 0) begin
                // Reconfigure only with the block empty.
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                case (cfg_round)
                    1: begin
                        set_step = 31'd1;
                        set_tol  = 31'd1;
                    end
                    2: begin
                        set_step = 31'h7FFF_FFFF;
                        set_tol  = 31'h7FFF_FFFF;
                    end
                    3: begin
                        set_step = 31'h7FFF_FFFF;
                        set_tol  = 31'd1;
                    end
                    4: begin
                        set_step = 31'd1;
                        set_tol  = 31'h7FFF_FFFF;
                    end
                    5: begin
                        set_step = $urandom_range(1, 1 << 20);
                        set_tol  = $urandom_range(1, 1 << 12);
                    end
                    6: begin
                        set_step = $urandom_range(1, 31'h7FFF_FFFF);
                        set_tol  = $urandom_range(1, 31'h7FFF_FFFF);
                    end
                    default: begin
                        set_step = CFG_RESET;
                        set_tol  = $urandom_range(1, 255);
                    end
                endcase
                write_reg(CFG_INITIAL_STEP, set_step);
                write_reg(CFG_TOLERANCE, set_tol);
            end
            if (cfg_round == 2) hold_go = 1'b1;
            pause_at = (cfg_round == 4) ? 3 : -1;
            target   = results_made + ITEMS_PER_SET;
            while (results_made < target || search_phase != PH_IDLE) begin
                run_search(pause_at);
                pause_at = -1;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/gsls_pkg.sv
hdl/gsls_mulk.sv
hdl/gsls_core.sv
hdl/golden_section_line_search.sv
verif/tb_golden_section_line_search.sv
